>>> hw/rtl/vaft_pkg.sv
// shared types, constants and the cordic arctangent table for the vector angle block
package vaft_pkg;

  localparam int COORD_WIDTH         = 16;
  localparam int ANGLE_FRACTION_BITS = 16;
  localparam int CORDIC_STEPS        = 32;
  localparam int STEP_IDX_WIDTH      = $clog2(CORDIC_STEPS);
  localparam int WORK_WIDTH          = 64;
  localparam int TURN_WIDTH          = 32;
  localparam int Z_WIDTH             = 33;

  typedef logic signed [WORK_WIDTH-1:0] work_t;
  typedef logic signed [Z_WIDTH-1:0]    z_t;
  typedef logic [TURN_WIDTH-1:0]        turn_t;
  typedef logic [STEP_IDX_WIDTH-1:0]    step_t;

  localparam turn_t QUARTER_TURN       = 32'h4000_0000;
  localparam turn_t HALF_TURN          = 32'h8000_0000;
  localparam turn_t THREE_QUARTER_TURN = 32'hC000_0000;

  // 2*pi in units of 2^-32
  localparam logic [63:0] TWO_PI_Q32 = 64'h0000_0006_487E_D511;

  typedef enum logic {
    UNIT_RADIANS = 1'b0,
    UNIT_DEGREES = 1'b1
  } unit_t;

  // register index taken from paddr[2]
  localparam logic REG_UNIT_MODE = 1'b0;

  typedef struct packed {
    logic x_zero;
    logic x_neg;
    logic y_pos;
    logic y_neg;
  } quad_t;

  // atan(2^-i) as a fraction of a turn times 2^32
  function automatic turn_t atan_turn(input step_t idx);
    turn_t r;
    unique case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      5'd31: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/vaft_if.sv
// valid/ready stream interfaces for points in and angles out
interface vaft_point_if #(
  parameter int COORD_WIDTH = vaft_pkg::COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x_coord;
  logic signed [COORD_WIDTH-1:0] y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface vaft_angle_if #(
  parameter int ANGLE_WIDTH = vaft_pkg::ANGLE_FRACTION_BITS + 9
);
  logic                   valid;
  logic                   ready;
  logic [ANGLE_WIDTH-1:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

>>> hw/rtl/vector_angle_full_turn.sv
// top level: point to full-turn angle in radians or degrees, apb register port
// registers in order: prep, cordic stages, unfold, partial products, rounded sum, wrapped angle
// throughput: one point per cycle unless stalled, via the 32-stage cordic and split multiplier
// the whole pipeline holds while a finished angle waits at the output register
// reset clears all stage valid bits and sets unit_mode to radians
module vector_angle_full_turn #(
  parameter int COORD_WIDTH         = vaft_pkg::COORD_WIDTH,
  parameter int ANGLE_FRACTION_BITS = vaft_pkg::ANGLE_FRACTION_BITS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  vaft_point_if.sink   point,
  vaft_angle_if.source result
);

  localparam int KW         = ANGLE_FRACTION_BITS + 9;
  localparam int SW         = KW + 33;
  localparam int WORK_SHIFT = 61 - COORD_WIDTH;
  localparam int TW         = vaft_pkg::TURN_WIDTH;
  localparam int HW         = TW / 2;

  localparam logic [63:0] K_RAD_WIDE =
    (vaft_pkg::TWO_PI_Q32 + (64'd1 << (31 - ANGLE_FRACTION_BITS))) >> (32 - ANGLE_FRACTION_BITS);
  localparam logic [KW-1:0] K_RAD      = K_RAD_WIDE[KW-1:0];
  localparam logic [KW-1:0] K_DEG      = KW'(360) << ANGLE_FRACTION_BITS;
  localparam logic [SW-1:0] ROUND_HALF = SW'(1) << (TW - 1);

  // configuration
  vaft_pkg::unit_t unit_mode;
  logic            reg_sel;

  assign reg_sel = (paddr[2] == vaft_pkg::REG_UNIT_MODE);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {31'd0, unit_mode} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_mode <= vaft_pkg::UNIT_RADIANS;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      unit_mode <= vaft_pkg::unit_t'(pwdata[0]);
    end
  end

  // pipeline enable
  logic out_valid;
  logic en;

  assign en          = !out_valid || result.ready;
  assign point.ready = en;

  // fold to first quadrant
  logic signed [COORD_WIDTH-1:0] x;
  logic signed [COORD_WIDTH-1:0] y;
  logic [COORD_WIDTH:0]          ax;
  logic [COORD_WIDTH:0]          ay;
  vaft_pkg::quad_t               quad_in;

  assign x  = point.x_coord;
  assign y  = point.y_coord;
  assign ax = x[COORD_WIDTH-1] ? ((COORD_WIDTH+1)'(0) - {x[COORD_WIDTH-1], x}) : {1'b0, x};
  assign ay = y[COORD_WIDTH-1] ? ((COORD_WIDTH+1)'(0) - {y[COORD_WIDTH-1], y}) : {1'b0, y};

  assign quad_in.x_zero = (x == '0);
  assign quad_in.x_neg  = x[COORD_WIDTH-1];
  assign quad_in.y_neg  = y[COORD_WIDTH-1];
  assign quad_in.y_pos  = !y[COORD_WIDTH-1] && (y != '0);

  logic            prep_valid;
  vaft_pkg::quad_t prep_quad;
  vaft_pkg::work_t prep_x;
  vaft_pkg::work_t prep_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      prep_valid <= 1'b0;
    end else if (en) begin
      prep_valid <= point.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep_quad <= quad_in;
      prep_x    <= vaft_pkg::work_t'(ax) << WORK_SHIFT;
      prep_y    <= vaft_pkg::work_t'(ay) << WORK_SHIFT;
    end
  end

  // cordic
  logic            cor_valid;
  vaft_pkg::quad_t cor_quad;
  vaft_pkg::z_t    cor_z;

  vaft_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (prep_valid),
    .in_quad   (prep_quad),
    .in_x      (prep_x),
    .in_y      (prep_y),
    .out_valid (cor_valid),
    .out_quad  (cor_quad),
    .out_z     (cor_z)
  );

  // clamp and unfold quadrant
  vaft_pkg::turn_t t_clamp;
  vaft_pkg::turn_t turn_next;

  always_comb begin
    if (cor_z[vaft_pkg::Z_WIDTH-1]) begin
      t_clamp = '0;
    end else if (cor_z > vaft_pkg::z_t'(vaft_pkg::QUARTER_TURN)) begin
      t_clamp = vaft_pkg::QUARTER_TURN;
    end else begin
      t_clamp = cor_z[TW-1:0];
    end

    priority if (cor_quad.x_zero) begin
      turn_next = cor_quad.y_pos ? vaft_pkg::QUARTER_TURN : vaft_pkg::THREE_QUARTER_TURN;
    end else if (!cor_quad.x_neg && !cor_quad.y_neg) begin
      turn_next = t_clamp;
    end else if (cor_quad.x_neg && !cor_quad.y_neg) begin
      turn_next = vaft_pkg::HALF_TURN - t_clamp;
    end else if (cor_quad.x_neg) begin
      turn_next = vaft_pkg::HALF_TURN + t_clamp;
    end else begin
      turn_next = '0 - t_clamp;
    end
  end

  logic            unf_valid;
  vaft_pkg::turn_t turn;

  always_ff @(posedge clk) begin
    if (rst) begin
      unf_valid <= 1'b0;
    end else if (en) begin
      unf_valid <= cor_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      turn <= turn_next;
    end
  end

  // scale: two half-width partial products, then sum with rounding, then wrap
  logic [KW-1:0]    k;
  logic             mul_valid;
  logic [KW+HW-1:0] p_hi;
  logic [KW+HW-1:0] p_lo;
  logic [SW-1:0]    sum;
  logic             sum_valid;
  logic [KW-1:0]    angle_raw;
  logic [KW-1:0]    angle;

  assign k   = (unit_mode == vaft_pkg::UNIT_DEGREES) ? K_DEG : K_RAD;
  assign sum = SW'({p_hi, HW'(0)}) + SW'(p_lo) + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
      sum_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      mul_valid <= unf_valid;
      sum_valid <= mul_valid;
      out_valid <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_hi      <= turn[TW-1:HW] * k;
      p_lo      <= turn[HW-1:0] * k;
      angle_raw <= sum[TW +: KW];
      angle     <= (angle_raw >= k) ? '0 : angle_raw;
    end
  end

  assign result.valid = out_valid;
  assign result.angle = angle;

endmodule

>>> hw/rtl/vaft_cordic.sv
// pipelined cordic in vectoring mode, one register stage per iteration
module vaft_cordic (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  vaft_pkg::quad_t in_quad,
  input  vaft_pkg::work_t in_x,
  input  vaft_pkg::work_t in_y,
  output logic            out_valid,
  output vaft_pkg::quad_t out_quad,
  output vaft_pkg::z_t    out_z
);

  localparam int STEPS = vaft_pkg::CORDIC_STEPS;

  vaft_pkg::work_t cx  [0:STEPS];
  vaft_pkg::work_t cy  [0:STEPS];
  vaft_pkg::z_t    z   [0:STEPS];
  vaft_pkg::quad_t qd  [0:STEPS];
  logic            vld [0:STEPS];

  assign cx[0]  = in_x;
  assign cy[0]  = in_y;
  assign z[0]   = '0;
  assign qd[0]  = in_quad;
  assign vld[0] = in_valid;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    vaft_pkg::work_t dx;
    vaft_pkg::work_t dy;
    vaft_pkg::z_t    da;

    assign dx = cy[i] >>> i;
    assign dy = cx[i] >>> i;
    assign da = vaft_pkg::z_t'(vaft_pkg::atan_turn(vaft_pkg::step_t'(i)));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        qd[i+1] <= qd[i];
        if (!cy[i][vaft_pkg::WORK_WIDTH-1]) begin
          cx[i+1] <= cx[i] + dx;
          cy[i+1] <= cy[i] - dy;
          z[i+1]  <= z[i] + da;
        end else begin
          cx[i+1] <= cx[i] - dx;
          cy[i+1] <= cy[i] + dy;
          z[i+1]  <= z[i] - da;
        end
      end
    end
  end

  assign out_valid = vld[STEPS];
  assign out_quad  = qd[STEPS];
  assign out_z     = z[STEPS];

endmodule
